// ----- src/wfcp_pkg.sv -----
// Shared types and constants for the WLAN frame command parser.
package wfcp_pkg;

    // Body marker and command codes
    localparam logic [7:0] BODY_MARK = 8'hdd;
    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_RESET = 8'h02;
    localparam logic [7:0] CMD_STOP  = 8'h03;

    // Result actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    // Frame control type field
    localparam logic [1:0] FT_MGMT = 2'd0;
    localparam logic [1:0] FT_CTRL = 2'd1;
    localparam logic [1:0] FT_DATA = 2'd2;

    // Control subtypes with non-minimal header
    localparam logic [3:0] SUB_CTRL_LONG = 4'd12;
    localparam logic [3:0] SUB_PS_POLL   = 4'd10;
    localparam logic [3:0] SUB_RTS       = 4'd11;

    // Header length pieces (bytes)
    localparam int HL_BITS     = 6;
    localparam int HL_FULL     = 24;
    localparam int HL_MID      = 16;
    localparam int HL_SHORT    = 10;
    localparam int HL_ADDR4    = 6;
    localparam int HL_QOS      = 2;
    localparam int HL_HTC      = 4;

    // Body layout: marker, command, then 8 bytes of elapsed time
    localparam int BODY_CTRL_LEN  = 2;
    localparam int BODY_START_LEN = 10;

    typedef logic [HL_BITS-1:0] t_hdr_len;

    // One byte moving from the input register into the frame state
    typedef struct packed {
        logic       adv;
        logic       last;
        logic [7:0] data;
    } t_step;

    // Frame fields as they stand after the current byte
    typedef struct packed {
        logic [7:0]  marker;
        logic [7:0]  command;
        logic [63:0] elapsed;
        t_hdr_len    hl;
    } t_frame_view;

endpackage

// ----- src/wfcp_hdr_len.sv -----
// MAC header length decode from the frame control word (0 = reserved type).
module wfcp_hdr_len (
    input  logic [15:0]         i_fc,
    output wfcp_pkg::t_hdr_len  o_hl
);
    import wfcp_pkg::*;

    logic [3:0] w_sub;

    assign w_sub = i_fc[7:4];

    always_comb begin
        o_hl = '0;
        case (i_fc[3:2])
            FT_MGMT: begin
                o_hl = t_hdr_len'(HL_FULL);
            end
            FT_CTRL: begin
                if (w_sub == SUB_CTRL_LONG) begin
                    o_hl = t_hdr_len'(HL_FULL);
                end else if (w_sub inside {SUB_PS_POLL, SUB_RTS}) begin
                    o_hl = t_hdr_len'(HL_MID);
                end else begin
                    o_hl = t_hdr_len'(HL_SHORT);
                end
            end
            FT_DATA: begin
                o_hl = t_hdr_len'(HL_FULL)
                     + ((i_fc[9:8] == 2'b11) ? t_hdr_len'(HL_ADDR4) : '0)
                     + (i_fc[7]              ? t_hdr_len'(HL_QOS)   : '0)
                     + (i_fc[15]             ? t_hdr_len'(HL_HTC)   : '0);
            end
            default: begin
                o_hl = '0;
            end
        endcase
    end

endmodule

// ----- src/wfcp_capture.sv -----
// Per-frame byte counter and capture of frame control, marker, command, elapsed time.
module wfcp_capture #(
    parameter int COUNT_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wfcp_pkg::t_step        i_step,
    output logic [COUNT_BITS-1:0]  o_pos,
    output wfcp_pkg::t_frame_view  o_view
);
    import wfcp_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_count;
    logic [15:0]           r_fc;
    logic [7:0]            r_marker;
    logic [7:0]            r_command;
    logic [63:0]           r_elapsed;

    logic [15:0]           n_fc;
    logic [7:0]            n_marker;
    logic [7:0]            n_command;
    logic [63:0]           n_elapsed;

    t_hdr_len              w_hl;
    logic [COUNT_BITS-1:0] w_hl_z;
    logic [COUNT_BITS-1:0] w_off;
    logic                  w_in_body;
    logic [2:0]            w_lane;

    wfcp_hdr_len u_hdr_len (
        .i_fc (r_fc),
        .o_hl (w_hl)
    );

    assign w_hl_z    = {{(COUNT_BITS-HL_BITS){1'b0}}, w_hl};
    assign w_in_body = (r_count >= COUNT_BITS'(2)) && (w_hl != '0) && (r_count >= w_hl_z);
    assign w_off     = r_count - w_hl_z;
    // body offsets 2..9 map onto byte lanes 0..7
    assign w_lane    = w_off[2:0] - 3'd2;

    always_comb begin
        n_fc      = r_fc;
        n_marker  = r_marker;
        n_command = r_command;
        n_elapsed = r_elapsed;
        if (r_count == '0) begin
            n_fc[7:0] = i_step.data;
        end else if (r_count == COUNT_BITS'(1)) begin
            n_fc[15:8] = i_step.data;
        end else if (w_in_body) begin
            if (w_off == '0) begin
                n_marker = i_step.data;
            end else if (w_off == COUNT_BITS'(1)) begin
                n_command = i_step.data;
            end else if (w_off < COUNT_BITS'(BODY_START_LEN)) begin
                n_elapsed = r_elapsed | ({56'd0, i_step.data} << {w_lane, 3'b000});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_fc      <= '0;
            r_marker  <= '0;
            r_command <= '0;
            r_elapsed <= '0;
        end else if (i_step.adv) begin
            if (i_step.last) begin
                r_count   <= '0;
                r_fc      <= '0;
                r_marker  <= '0;
                r_command <= '0;
                r_elapsed <= '0;
            end else begin
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + COUNT_BITS'(1);
                end
                r_fc      <= n_fc;
                r_marker  <= n_marker;
                r_command <= n_command;
                r_elapsed <= n_elapsed;
            end
        end
    end

    assign o_pos          = r_count;
    assign o_view.marker  = n_marker;
    assign o_view.command = n_command;
    assign o_view.elapsed = n_elapsed;
    assign o_view.hl      = w_hl;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.adv && i_step.last |=> r_count == '0 && r_fc == '0 && r_elapsed == '0)
        else $error("frame state not cleared after last byte");

endmodule

// ----- src/wlan_frame_command_parser_unit.sv -----
// Top level: 802.11 frame byte stream in, one command result per frame out.
//
// Path: a frame's last byte passes the input register, then loads the result
//   register once that register is free.
// Throughput: one byte per cycle; the input side stalls only when the last byte
//   of a frame waits for a result register that is still held by m_tready low.
// Reset: i_rst_n synchronous, active low; clears valids and all frame state.
module wlan_frame_command_parser_unit #(
    parameter int COUNT_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // receive byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [1:0] action, [65:2] elapsed_time, [71:66] zero
);
    import wfcp_pkg::*;

    // input register
    logic        r_in_valid;
    logic        r_in_last;
    logic [7:0]  r_in_data;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_out_action;
    logic [63:0] r_out_elapsed;

    logic        w_out_free;
    logic        w_adv;
    logic        w_s_xact;

    t_step                 w_step;
    t_frame_view           w_view;
    logic [COUNT_BITS-1:0] w_pos;
    logic [COUNT_BITS-1:0] w_hl_z;

    logic [1:0]  n_action;
    logic [63:0] n_elapsed;

    // Non-last bytes always move on; the last byte needs the result slot free.
    assign w_out_free = !r_out_valid || m_tready;
    assign w_adv      = r_in_valid && (!r_in_last || w_out_free);
    assign s_tready   = !r_in_valid || w_adv;
    assign w_s_xact   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_xact) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xact) begin
            r_in_data <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    assign w_step.adv  = w_adv;
    assign w_step.last = r_in_last;
    assign w_step.data = r_in_data;

    wfcp_capture #(
        .COUNT_BITS (COUNT_BITS)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_pos   (w_pos),
        .o_view  (w_view)
    );

    // Decision on the last byte. w_pos is the byte's index, so frame length is
    // w_pos + 1; "length >= hl + n" is written as "w_pos >= hl + n - 1".
    assign w_hl_z = {{(COUNT_BITS-HL_BITS){1'b0}}, w_view.hl};

    always_comb begin
        n_action  = ACT_NONE;
        n_elapsed = '0;
        if ((w_pos >= COUNT_BITS'(1)) && (w_view.hl != '0)
                && (w_pos >= w_hl_z + COUNT_BITS'(BODY_CTRL_LEN - 1))
                && (w_view.marker == BODY_MARK)) begin
            case (w_view.command)
                CMD_START: begin
                    if (w_pos >= w_hl_z + COUNT_BITS'(BODY_START_LEN - 1)) begin
                        n_action  = ACT_START;
                        n_elapsed = w_view.elapsed;
                    end
                end
                CMD_RESET: begin
                    n_action = ACT_RESET;
                end
                CMD_STOP: begin
                    n_action = ACT_STOP;
                end
                default: begin
                    n_action = ACT_NONE;
                end
            endcase
        end
    end

    // result register: loaded by the last byte of each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_action  <= n_action;
            r_out_elapsed <= n_elapsed;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out_elapsed, r_out_action};

    a_mid_frame_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in_last |-> w_adv)
        else $error("mid-frame byte stalled");

    a_elapsed_only_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_action != ACT_START |-> r_out_elapsed == '0)
        else $error("elapsed time on non-start result");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_last |=> r_out_valid)
        else $error("last byte produced no result");

endmodule

// ----- test/tb_wlan_frame_command_parser_unit.sv -----
// Testbench for wlan_frame_command_parser_unit: byte streams checked against predicted commands.
`timescale 1ns / 100ps

module tb_wlan_frame_command_parser_unit;
    import wfcp_pkg::*;

    localparam int COUNT_BITS     = 8;     // narrow counter keeps the saturating frame short
    localparam int MAX_WAIT       = 11;    // longest idle drawn per transaction, either side
    localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transaction
    localparam int RAND_BYTES     = 870;
    localparam int SETTLE_CYCLES  = 16;    // two-stage pipe plus margin
    localparam logic [1:0] FT_RSVD = 2'd3;

    // One frame byte waiting to be driven, with its lead-in gap
    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
        bit         hold;   // wait for all outstanding commands before this byte
    } t_frame_byte;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] elapsed;
    } t_cmd_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;            // [1:0] action, [65:2] elapsed_time, [71:66] zero

    t_frame_byte rx_bytes[$];        // stimulus not yet driven
    t_cmd_result pending_cmds[$];    // predicted results not yet seen

    // Predicted frame state
    logic [COUNT_BITS-1:0] fr_count   = '0;
    logic [15:0]           fr_fc      = '0;
    logic [7:0]            fr_marker  = '0;
    logic [7:0]            fr_cmd     = '0;
    logic [63:0]           fr_elapsed = '0;

    bit hold_next = 1'b0;
    bit quiet_rx  = 1'b0;
    int waited = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int n_errors = 0;
    int n_frames = 0;
    int n_bytes = 0;
    int n_results = 0;
    int long_len = 0;
    int act_seen[4] = '{0, 0, 0, 0};

    always #1 i_clk = ~i_clk;

    wlan_frame_command_parser_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // MAC header length from frame control; 0 flags the reserved type
    function automatic int hdr_len(logic [15:0] fc);
        int hl;
        hl = 0;
        case (fc[3:2])
            FT_MGMT: hl = HL_FULL;
            FT_CTRL: begin
                if (fc[7:4] == SUB_CTRL_LONG) hl = HL_FULL;
                else if (fc[7:4] == SUB_PS_POLL || fc[7:4] == SUB_RTS) hl = HL_MID;
                else hl = HL_SHORT;
            end
            FT_DATA: begin
                hl = HL_FULL;
                if (fc[9:8] == 2'b11) hl += HL_ADDR4;   // to-DS and from-DS
                if (fc[7]) hl += HL_QOS;                // QoS subtype bit
                if (fc[15]) hl += HL_HTC;               // order bit
            end
            default: hl = 0;
        endcase
        return hl;
    endfunction

    function automatic void clear_frame();
        fr_count   = '0;
        fr_fc      = '0;
        fr_marker  = '0;
        fr_cmd     = '0;
        fr_elapsed = '0;
    endfunction

    // Advance the predicted frame state by one byte; done marks a result
    function automatic void parse_byte(input logic [7:0] b, input logic last,
                                       output logic done, output t_cmd_result res);
        int pos;
        int hl;
        int off;
        int len;
        pos  = fr_count;
        done = 1'b0;
        res  = '0;
        if (pos == 0) begin
            fr_fc[7:0] = b;
        end else if (pos == 1) begin
            fr_fc[15:8] = b;
        end else begin
            hl = hdr_len(fr_fc);
            if (hl != 0 && pos >= hl) begin
                off = pos - hl;
                if (off == 0) fr_marker = b;
                else if (off == 1) fr_cmd = b;
                else if (off < BODY_START_LEN) fr_elapsed[8*(off-2) +: 8] = b;
            end
        end
        // counter holds at its top value on very long frames
        if (fr_count != {COUNT_BITS{1'b1}}) fr_count = fr_count + 1'b1;
        if (last) begin
            done = 1'b1;
            len  = pos + 1;
            hl   = hdr_len(fr_fc);
            if (len >= 2 && hl != 0 && len >= hl + BODY_CTRL_LEN && fr_marker == BODY_MARK) begin
                case (fr_cmd)
                    CMD_START: begin
                        // start needs the full elapsed field
                        if (len >= hl + BODY_START_LEN) begin
                            res.action  = ACT_START;
                            res.elapsed = fr_elapsed;
                        end
                    end
                    CMD_RESET: res.action = ACT_RESET;
                    CMD_STOP:  res.action = ACT_STOP;
                    default:   res.action = ACT_NONE;
                endcase
            end
            clear_frame();
        end
    endfunction

    function automatic logic [15:0] mk_fc(logic [1:0] ft, logic [3:0] sub, logic [7:0] flags);
        return {flags, sub, ft, 2'b00};
    endfunction

    task automatic push_byte(logic [7:0] b, logic last, bit quiet);
        t_frame_byte fb;
        fb.data = b;
        fb.last = last;
        fb.gap  = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        fb.hold = hold_next;
        hold_next = 1'b0;
        rx_bytes.push_back(fb);
        n_bytes++;
    endtask

    // Frame laid out as header, marker, command, elapsed, padding; cut at len
    task automatic send_frame(logic [15:0] fc, logic [7:0] marker, logic [7:0] cmd,
                              logic [63:0] el, int len, bit quiet);
        int hl;
        int off;
        int i;
        logic [7:0] b;
        hl = hdr_len(fc);
        if (hl == 0) hl = HL_FULL;
        for (i = 0; i < len; i++) begin
            off = i - hl;
            if (i == 0) b = fc[7:0];
            else if (i == 1) b = fc[15:8];
            else if (off < 0) b = 8'($urandom);
            else if (off == 0) b = marker;
            else if (off == 1) b = cmd;
            else if (off < BODY_START_LEN) b = el[8*(off-2) +: 8];
            else b = 8'($urandom);
            push_byte(b, i == len - 1, quiet);
        end
        n_frames++;
    endtask

    task automatic send_noise(int len, bit quiet);
        int i;
        for (i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1, quiet);
        n_frames++;
    endtask

    // Sender: one byte per transaction, gap and drain hold applied at the head
    always @(posedge i_clk) begin : drive_p
        t_frame_byte cur;
        t_cmd_result res;
        logic        done;
        logic        nv;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            waited = 0;
            clear_frame();
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast, done, res);
                if (done) pending_cmds.push_back(res);
                nv = 1'b0;
            end
            if (!nv && rx_bytes.size() != 0
                    && !(rx_bytes[0].hold && pending_cmds.size() != 0)) begin
                if (waited < rx_bytes[0].gap) begin
                    waited++;
                end else begin
                    cur = rx_bytes.pop_front();
                    s_tdata <= cur.data;
                    s_tlast <= cur.last;
                    nv = 1'b1;
                    waited = 0;
                end
            end
            s_tvalid <= nv;
        end
    end

    // Receiver: random stalls, with stretches of none; every result checked in order
    always @(posedge i_clk) begin : check_p
        t_cmd_result want;
        logic        nr;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            nr = m_tready;
            if (m_tvalid && m_tready) begin
                if (pending_cmds.size() == 0) begin
                    $error("unexpected result: action %0d elapsed_time 0x%016h",
                           m_tdata[1:0], m_tdata[65:2]);
                    n_errors++;
                end else begin
                    want = pending_cmds.pop_front();
                    if (m_tdata[1:0] !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, m_tdata[1:0]);
                        n_errors++;
                    end
                    if (m_tdata[65:2] !== want.elapsed) begin
                        $error("elapsed_time: expected 0x%016h, got 0x%016h",
                               want.elapsed, m_tdata[65:2]);
                        n_errors++;
                    end
                    if (m_tdata[71:66] !== 6'd0) begin
                        $error("tdata pad: expected 0, got 0x%02h", m_tdata[71:66]);
                        n_errors++;
                    end
                    act_seen[want.action]++;
                end
                n_results++;
                if ($urandom_range(0, 15) == 0) quiet_rx = !quiet_rx;
                stall_left = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
                nr = (stall_left == 0);
            end else if (!m_tready) begin
                if (stall_left > 0) stall_left--;
                nr = (stall_left == 0);
            end
            m_tready <= nr;
        end
    end

    // Watchdog: a hang on either side ends the run
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [15:0] fc;
        logic [7:0]  marker;
        logic [7:0]  cmd;
        logic [63:0] el;
        int          hl;
        int          len;
        int          pick;
        int          rand_bytes;
        bit          quiet;

        // Directed frames: lengths at each threshold, every command, every header shape
        send_noise(1, 0);                                                 // one-byte frame
        send_frame(mk_fc(FT_MGMT, 4'd0, 8'h00), BODY_MARK, CMD_START, '0, 2, 0);
        hold_next = 1'b1;
        send_frame(mk_fc(FT_MGMT, 4'd8, 8'h00), BODY_MARK, CMD_START,
                   64'hffff_ffff_ffff_ffff, HL_FULL + BODY_START_LEN, 1);   // exact start
        send_frame(mk_fc(FT_MGMT, 4'd4, 8'h00), BODY_MARK, CMD_START,
                   64'h0123_4567_89ab_cdef, HL_FULL + BODY_START_LEN + 3, 0);
        send_frame(mk_fc(FT_MGMT, 4'd5, 8'h00), BODY_MARK, CMD_START,
                   64'h0123_4567_89ab_cdef, HL_FULL + BODY_START_LEN - 1, 0); // one short
        send_frame(mk_fc(FT_MGMT, 4'd0, 8'h00), BODY_MARK, CMD_RESET, '0,
                   HL_FULL + BODY_CTRL_LEN, 1);
        send_frame(mk_fc(FT_MGMT, 4'd0, 8'h00), BODY_MARK, CMD_STOP, '0, HL_FULL + 5, 0);
        send_frame(mk_fc(FT_MGMT, 4'd0, 8'h00), BODY_MARK, 8'h04, '0, HL_FULL + 12, 0);
        send_frame(mk_fc(FT_MGMT, 4'd0, 8'h00), 8'hdc, CMD_RESET, '0, HL_FULL + 12, 0);
        send_frame(mk_fc(FT_MGMT, 4'd0, 8'h00), BODY_MARK, CMD_RESET, '0,
                   HL_FULL + 1, 0);                                        // no command byte
        send_frame(mk_fc(FT_RSVD, 4'd0, 8'h00), BODY_MARK, CMD_START, 64'h55, 40, 0);
        send_frame(mk_fc(FT_CTRL, SUB_CTRL_LONG, 8'h00), BODY_MARK, CMD_START,
                   64'h8000_0000_0000_0001, HL_FULL + BODY_START_LEN, 0);
        send_frame(mk_fc(FT_CTRL, SUB_PS_POLL, 8'h00), BODY_MARK, CMD_RESET, '0,
                   HL_MID + BODY_CTRL_LEN, 1);
        send_frame(mk_fc(FT_CTRL, SUB_RTS, 8'h00), BODY_MARK, CMD_STOP, '0, HL_MID + 4, 0);
        send_frame(mk_fc(FT_CTRL, 4'd13, 8'h00), BODY_MARK, CMD_START,
                   64'h7f7f_0000_ffff_1234, HL_SHORT + BODY_START_LEN, 0);
        send_frame(mk_fc(FT_DATA, 4'd0, 8'h00), BODY_MARK, CMD_START,
                   64'hdead_beef_0000_0042, HL_FULL + BODY_START_LEN, 0);
        send_frame(mk_fc(FT_DATA, 4'd0, 8'h03), BODY_MARK, CMD_START,
                   64'h1111_2222_3333_4444, HL_FULL + HL_ADDR4 + BODY_START_LEN, 0);
        send_frame(mk_fc(FT_DATA, 4'd8, 8'h00), BODY_MARK, CMD_RESET, '0,
                   HL_FULL + HL_QOS + BODY_CTRL_LEN, 0);
        send_frame(mk_fc(FT_DATA, 4'd0, 8'h80), BODY_MARK, CMD_STOP, '0,
                   HL_FULL + HL_HTC + BODY_CTRL_LEN, 1);
        send_frame(mk_fc(FT_DATA, 4'd8, 8'h83), BODY_MARK, CMD_START, 64'hfedc_ba98_7654_3210,
                   HL_FULL + HL_ADDR4 + HL_QOS + HL_HTC + BODY_START_LEN, 0);

        // Random frames: mostly well formed, some truncated, some plain noise
        rand_bytes = 0;
        while (rand_bytes < RAND_BYTES) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 19) == 0) hold_next = 1'b1;
            if ($urandom_range(0, 6) == 0) begin
                len = $urandom_range(1, 40);
                send_noise(len, quiet);
            end else begin
                pick = $urandom_range(0, 19);
                fc = 16'($urandom);
                fc[3:2] = (pick < 6) ? FT_MGMT : (pick < 10) ? FT_CTRL :
                          (pick < 19) ? FT_DATA : FT_RSVD;
                marker = ($urandom_range(0, 9) == 0) ? 8'($urandom) : BODY_MARK;
                pick = $urandom_range(0, 9);
                cmd = (pick < 4) ? CMD_START : (pick < 6) ? CMD_RESET :
                      (pick < 8) ? CMD_STOP : 8'($urandom);
                el = {$urandom, $urandom};
                hl = hdr_len(fc);
                if (hl == 0) hl = HL_FULL;
                if ($urandom_range(0, 4) == 0) len = $urandom_range(1, hl + BODY_START_LEN + 1);
                else len = hl + BODY_START_LEN + $urandom_range(0, 6);
                send_frame(fc, marker, cmd, el, len, quiet);
            end
            rand_bytes += len;
        end

        // One frame long enough to pin the byte counter at its top value
        long_len = $urandom_range(1 << COUNT_BITS, (1 << COUNT_BITS) + 100);
        send_frame(mk_fc(FT_DATA, 4'd8, 8'h03), BODY_MARK, CMD_START,
                   {$urandom, $urandom}, long_len, 1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample at the falling edge so driver and checker updates have settled
        @(negedge i_clk);
        while (rx_bytes.size() != 0 || s_tvalid || pending_cmds.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Ran %0d frames, %0d bytes, one of %0d bytes past the counter top; %0d results.",
                 n_frames, n_bytes, long_len, n_results);
        $display("Commands seen: none %0d, start %0d, reset %0d, stop %0d.",
                 act_seen[ACT_NONE], act_seen[ACT_START], act_seen[ACT_RESET],
                 act_seen[ACT_STOP]);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
